// File: hw/rtl/arc4dk_pkg.sv
// Shared constants and types for the double-keystream byte cipher core.
package arc4dk_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned MODE_W       = 3;
	localparam int unsigned PERM_DEPTH   = 256;
	localparam int unsigned IDX_W        = $clog2(PERM_DEPTH);
	localparam int unsigned WARMUP_STEPS = 3072;
	localparam int unsigned WARM_CNT_W   = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;

	localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_KEY    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WARMUP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STREAM = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ENC    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEC    = 3'd5;

	// permutation read address source
	typedef enum logic [2:0] {
		RD_I    = 3'd0,
		RD_I1   = 3'd1,
		RD_J    = 3'd2,
		RD_JSUM = 3'd3,
		RD_T    = 3'd4
	} arc4dk_rd_sel_t;

	typedef enum logic [1:0] {
		J_HOLD    = 2'd0,
		J_ADD_S   = 2'd1,
		J_ADD_KEY = 2'd2
	} arc4dk_j_op_t;

	typedef enum logic [1:0] {
		RES_STREAM = 2'd0,
		RES_ENC    = 2'd1,
		RES_DEC    = 2'd2
	} arc4dk_res_op_t;

	typedef struct packed {
		logic           latch;
		logic           clr_idx;
		logic           clr_valid;
		logic           rd_en;
		arc4dk_rd_sel_t rd_sel;
		logic           i_inc;
		arc4dk_j_op_t   j_op;
		logic           cap_si;
		logic           wr_i;
		logic           wr_j;
		logic           cap_k1;
		logic           load_out;
		arc4dk_res_op_t res_op;
	} arc4dk_cmd_t;

	typedef struct packed {
		logic out_full;
	} arc4dk_status_t;

endpackage

// File: hw/rtl/arc4dk_if.sv
// Valid/ready channel interfaces for the cipher core's items and results.
interface arc4dk_item_if import arc4dk_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] data_byte;
	logic              segment_end;

	modport source (output valid, output mode, output data_byte, output segment_end,
		input ready);
	modport sink (input valid, input mode, input data_byte, input segment_end,
		output ready);
endinterface

interface arc4dk_result_if import arc4dk_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              segment_end_out;

	modport source (output valid, output out_byte, output segment_end_out, input ready);
	modport sink (input valid, input out_byte, input segment_end_out, output ready);
endinterface

// File: hw/rtl/arc4dk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arc4dk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/arc4dk_datapath.sv
// Datapath: permutation RAM with valid bits, indices, swap registers and result register.
module arc4dk_datapath import arc4dk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  arc4dk_cmd_t       cmd,
	output arc4dk_status_t    status,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              segment_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              segment_end_out
);

	logic [IDX_W-1:0]      i_q, j_q;
	logic [BYTE_W-1:0]     data_q;
	logic                  seg_q;
	logic [BYTE_W-1:0]     si_q, sj_q, k1_q;
	logic [PERM_DEPTH-1:0] vld_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic                  rd_vld_q;
	logic                  byp_q;
	logic                  out_vld_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_seg_q;

	logic [IDX_W-1:0]  raddr, waddr;
	logic [BYTE_W-1:0] wdata, ram_rdata, rdval, res;
	logic              we;

	// entries not written since init read as identity
	assign rdval = byp_q ? si_q : (rd_vld_q ? ram_rdata : rd_addr_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_I:    raddr = i_q;
			RD_I1:   raddr = i_q + IDX_W'(1);
			RD_J:    raddr = j_q;
			RD_JSUM: raddr = j_q + rdval;
			RD_T:    raddr = si_q + sj_q;
			default: raddr = i_q;
		endcase
	end

	assign we    = cmd.wr_i | cmd.wr_j;
	assign waddr = cmd.wr_i ? i_q : j_q;
	assign wdata = cmd.wr_i ? rdval : si_q;

	arc4dk_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PERM_DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			vld_q <= '0;
		end else begin
			if (cmd.clr_idx) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + IDX_W'(1);
			end
			if (cmd.clr_idx) begin
				j_q <= '0;
			end else begin
				case (cmd.j_op)
					J_ADD_S:   j_q <= j_q + rdval;
					J_ADD_KEY: j_q <= j_q + rdval + data_q;
					default:   j_q <= j_q;
				endcase
			end
			if (cmd.clr_valid) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	// read-side tags; the t read bypasses the j write issued in the same cycle
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_addr_q <= raddr;
			rd_vld_q  <= vld_q[raddr];
			byp_q     <= (cmd.rd_sel == RD_T) && (raddr == j_q);
		end
		if (cmd.latch) begin
			data_q <= data_byte;
			seg_q  <= segment_end;
		end
		if (cmd.cap_si) begin
			si_q <= rdval;
		end
		if (cmd.wr_i) begin
			sj_q <= rdval;
		end
		if (cmd.cap_k1) begin
			k1_q <= rdval;
		end
	end

	always_comb begin
		case (cmd.res_op)
			RES_ENC: res = (data_q ^ k1_q) + rdval;
			RES_DEC: res = (data_q - rdval) ^ k1_q;
			default: res = rdval;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_byte_q <= res;
			out_seg_q  <= seg_q;
		end
	end

	assign status.out_full = out_vld_q & ~out_ready;
	assign out_valid       = out_vld_q;
	assign out_byte        = out_byte_q;
	assign segment_end_out = out_seg_q;

endmodule

// File: hw/rtl/arc4dk_ctrl.sv
// Controller: sequences init, key mixing, warmup and keystream steps over the datapath.
module arc4dk_ctrl import arc4dk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [MODE_W-1:0] item_mode,
	output logic              item_ready,
	output arc4dk_cmd_t       cmd,
	input  arc4dk_status_t    status
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_INIT = 11'b000_0000_0010,
		ST_WCLR = 11'b000_0000_0100,
		ST_KA   = 11'b000_0000_1000,
		ST_KB   = 11'b000_0001_0000,
		ST_KC   = 11'b000_0010_0000,
		ST_SA   = 11'b000_0100_0000,
		ST_SB   = 11'b000_1000_0000,
		ST_SC   = 11'b001_0000_0000,
		ST_SD   = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} arc4dk_state_t;

	arc4dk_state_t         state_q, state_d;
	logic [MODE_W-1:0]     mode_q;
	logic                  second_q;
	logic [WARM_CNT_W-1:0] cnt_q;
	logic                  accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid & item_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item_mode)
						MODE_INIT:   state_d = ST_INIT;
						MODE_KEY:    state_d = ST_KA;
						MODE_WARMUP: state_d = ST_WCLR;
						MODE_STREAM,
						MODE_ENC,
						MODE_DEC:    state_d = ST_SA;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: state_d = ST_IDLE;
			ST_WCLR: state_d = (cnt_q == '0) ? ST_IDLE : ST_SA;
			ST_KA:   state_d = ST_KB;
			ST_KB:   state_d = ST_KC;
			ST_KC:   state_d = ST_SC;
			ST_SA:   state_d = ST_SB;
			ST_SB:   state_d = ST_SC;
			ST_SC:   state_d = ST_SD;
			ST_SD: begin
				case (mode_q)
					MODE_KEY:    state_d = ST_IDLE;
					MODE_WARMUP: state_d = (cnt_q == WARM_CNT_W'(1)) ? ST_IDLE : ST_SA;
					MODE_STREAM: state_d = ST_FIN;
					default:     state_d = second_q ? ST_FIN : ST_SA;
				endcase
			end
			ST_FIN:  state_d = status.out_full ? ST_FIN : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_INIT;
			second_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q   <= item_mode;
				second_q <= 1'b0;
				cnt_q    <= WARM_CNT_W'(WARMUP_STEPS);
			end else if (state_q == ST_SD) begin
				second_q <= 1'b1;
				if (mode_q == MODE_WARMUP) begin
					cnt_q <= cnt_q - WARM_CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.rd_sel    = RD_I;
		cmd.j_op      = J_HOLD;
		cmd.latch     = accept;
		case (mode_q)
			MODE_ENC: cmd.res_op = RES_ENC;
			MODE_DEC: cmd.res_op = RES_DEC;
			default:  cmd.res_op = RES_STREAM;
		endcase
		case (state_q)
			ST_INIT: begin
				cmd.clr_idx   = 1'b1;
				cmd.clr_valid = 1'b1;
			end
			ST_WCLR: cmd.clr_idx = 1'b1;
			ST_KA: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_I;
			end
			ST_KB: begin
				// j += S[i] + key, then fetch S[i+1]
				cmd.j_op   = J_ADD_KEY;
				cmd.i_inc  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_I1;
			end
			ST_KC: begin
				cmd.cap_si = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_J;
			end
			ST_SA: begin
				// the previous step's output byte is on the read data here
				cmd.cap_k1 = second_q;
				cmd.i_inc  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_I1;
			end
			ST_SB: begin
				cmd.cap_si = 1'b1;
				cmd.j_op   = J_ADD_S;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_JSUM;
			end
			ST_SC: cmd.wr_i = 1'b1;
			ST_SD: begin
				cmd.wr_j   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_T;
			end
			ST_FIN: cmd.load_out = ~status.out_full;
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/arc4_double_keystream_cipher_core.sv
// RC4-style byte cipher core with a double keystream per data byte. One item is
// worked at a time; the core is ready again once the item's work is done, while an
// earlier result may still sit in the output register. After the accept cycle an
// item steps through: init ST_INIT; key byte KA, KB, KC, SC, SD; keystream SA to SD
// then FIN; encrypt or decrypt SA to SD twice, then FIN; warmup WCLR, then SA to SD
// once per step for WARMUP_STEPS steps; unused mode codes go straight back to idle.
// Keystream, encrypt and decrypt hold in FIN while the output register holds a result
// that is not yet taken. A keystream step runs through SA, SB, SC and SD, since the
// single permutation RAM has one read and one write port and each step needs three
// reads and two writes in dependent order. Init clears a per-entry valid bit array,
// so no clearing pass is needed after reset or init.
module arc4_double_keystream_cipher_core import arc4dk_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	arc4dk_item_if.sink     item,
	arc4dk_result_if.source result
);

	arc4dk_cmd_t    cmd;
	arc4dk_status_t status;

	arc4dk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_ready (item.ready),
		.cmd        (cmd),
		.status     (status)
	);

	arc4dk_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.data_byte       (item.data_byte),
		.segment_end     (item.segment_end),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_byte        (result.out_byte),
		.segment_end_out (result.segment_end_out)
	);

endmodule

// File: hw/rtl/arc4dk_checker.sv
// Port-level assertions for the cipher core, bound to its top level.
module arc4dk_checker import arc4dk_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic [MODE_W-1:0] item_mode,
	input logic              result_valid,
	input logic              result_ready,
	input logic [BYTE_W-1:0] result_byte
);

	// a result is held until the transaction completes
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_byte))
		else $error("result dropped or changed while stalled");

	// any valid mode keeps the core busy for at least the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_mode == MODE_INIT || item_mode == MODE_KEY
		|| item_mode == MODE_WARMUP || item_mode == MODE_STREAM || item_mode == MODE_ENC
		|| item_mode == MODE_DEC) |=> !item_ready)
		else $error("core ready right after accepting a working mode");

	// no result can appear in the cycle right after an item transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result appeared too early");

	// a new result is only loaded while the core is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result loaded while core idle");

endmodule

bind arc4_double_keystream_cipher_core arc4dk_checker u_arc4dk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_mode    (item.mode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_byte  (result.out_byte)
);

// File: verif/arc4_double_keystream_cipher_core_tb.sv
// Self-checking testbench for the double-keystream byte cipher core.
module arc4_double_keystream_cipher_core_tb import arc4dk_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// mode codes the core must ignore
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam int unsigned       WARMUP_BUDGET = 10;
	localparam int unsigned       RANDOM_ITEMS  = 1000;
	localparam int unsigned       TAIL_CYCLES   = 64;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              seg_end;
	} cipher_result_t;

	class cipher_scoreboard;
		logic [BYTE_W-1:0] perm_state [PERM_DEPTH];
		logic [IDX_W-1:0]  ptr_i;
		logic [IDX_W-1:0]  ptr_j;
		cipher_result_t    expected_bytes [$];
		int unsigned       fail_count;
		int unsigned       checked_count;
		int unsigned       mode_seen [8];

		function new();
			load_identity();
			fail_count = 0;
			checked_count = 0;
			foreach (mode_seen[n]) mode_seen[n] = 0;
		endfunction

		function void load_identity();
			for (int n = 0; n < PERM_DEPTH; n++) perm_state[n] = n[BYTE_W-1:0];
			ptr_i = '0;
			ptr_j = '0;
		endfunction

		function void swap_entries();
			logic [BYTE_W-1:0] t;
			t = perm_state[ptr_i];
			perm_state[ptr_i] = perm_state[ptr_j];
			perm_state[ptr_j] = t;
		endfunction

		function logic [BYTE_W-1:0] next_key_byte();
			logic [IDX_W-1:0] sum;
			ptr_i = ptr_i + 1'b1;
			ptr_j = ptr_j + perm_state[ptr_i];
			swap_entries();
			sum = perm_state[ptr_i] + perm_state[ptr_j];
			return perm_state[sum];
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction

		// called for every accepted input transaction
		function void note_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
				logic seg_end);
			logic [BYTE_W-1:0] k1;
			logic [BYTE_W-1:0] k2;
			cipher_result_t    res;
			mode_seen[mode]++;
			res.seg_end = seg_end;
			case (mode)
				MODE_INIT: begin
					load_identity();
				end
				MODE_KEY: begin
					ptr_j = ptr_j + perm_state[ptr_i] + data;
					ptr_i = ptr_i + 1'b1;
					swap_entries();
				end
				MODE_WARMUP: begin
					ptr_i = '0;
					ptr_j = '0;
					for (int n = 0; n < WARMUP_STEPS; n++) void'(next_key_byte());
				end
				MODE_STREAM: begin
					res.out_byte = next_key_byte();
					expected_bytes.push_back(res);
				end
				MODE_ENC: begin
					k1 = next_key_byte();
					k2 = next_key_byte();
					res.out_byte = (data ^ k1) + k2;
					expected_bytes.push_back(res);
				end
				MODE_DEC: begin
					k1 = next_key_byte();
					k2 = next_key_byte();
					res.out_byte = (data - k2) ^ k1;
					expected_bytes.push_back(res);
				end
				default: begin
				end
			endcase
		endfunction

		// called for every accepted result transaction
		function void check_result(logic [BYTE_W-1:0] out_byte, logic seg_end);
			cipher_result_t want;
			checked_count++;
			if (expected_bytes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d: unexpected, out_byte %h segment_end_out %b",
						checked_count, out_byte, seg_end);
				return;
			end
			want = expected_bytes.pop_front();
			if (out_byte !== want.out_byte || seg_end !== want.seg_end) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d: out_byte exp %h got %h, segment_end_out exp %b got %b",
						checked_count, want.out_byte, out_byte, want.seg_end, seg_end);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	arc4dk_item_if   item_ch();
	arc4dk_result_if result_ch();

	arc4_double_keystream_cipher_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	cipher_scoreboard sb = new();
	bit               tx_calm;
	bit               rx_calm;
	int unsigned      items_sent;
	int unsigned      warmups_left;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
			input logic seg_end);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.mode        <= mode;
		item_ch.data_byte   <= data;
		item_ch.segment_end <= seg_end;
		item_ch.valid       <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(mode, data, seg_end);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (sb.pending() > 0) @(posedge clk);
	endtask

	// rounds of optional key setup and warmup, each then a data run with some noise mixed in
	task automatic run_random();
		int unsigned       run_len;
		int unsigned       pick;
		bit                pressured;
		logic [MODE_W-1:0] mode;
		pressured = 1'b0;
		while (items_sent < RANDOM_ITEMS) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			if (!pressured && items_sent >= RANDOM_ITEMS / 2) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
				wait_drained();
				pressured = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				send_item(MODE_INIT, BYTE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				repeat ($urandom_range(1, 16))
					send_item(MODE_KEY, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				if (warmups_left > 0 && $urandom_range(0, 2) == 0) begin
					send_item(MODE_WARMUP, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					warmups_left--;
				end
			end
			run_len = $urandom_range(4, 30);
			for (int n = 0; n < run_len; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					mode = MODE_W'($urandom_range(0, 7));
					if (mode == MODE_WARMUP) begin
						if (warmups_left > 0 && $urandom_range(0, 3) == 0)
							warmups_left--;
						else
							mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
					end
				end else begin
					case (pick % 3)
						0: mode = MODE_STREAM;
						1: mode = MODE_ENC;
						default: mode = MODE_DEC;
					endcase
				end
				send_item(mode, BYTE_W'($urandom_range(0, 255)),
					($urandom_range(0, 7) == 0) || (n == run_len - 1));
			end
		end
	endtask

	// result side: random stalls, with calm stretches
	initial begin
		int unsigned stall;
		int unsigned rx_count;
		result_ch.ready <= 1'b0;
		rx_calm = 1'b0;
		rx_count = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_result(result_ch.out_byte, result_ch.segment_end_out);
			rx_count++;
			if (rx_count % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still expected", sb.pending());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		item_ch.valid       <= 1'b0;
		item_ch.mode        <= MODE_INIT;
		item_ch.data_byte   <= '0;
		item_ch.segment_end <= 1'b0;
		arst_n              <= 1'b0;
		items_sent = 0;
		warmups_left = WARMUP_BUDGET;
		tx_calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight from reset: identity table, zero indices
		send_item(MODE_STREAM, 8'h00, 1'b0);
		send_item(MODE_ENC, 8'h00, 1'b0);
		send_item(MODE_ENC, 8'hff, 1'b1);
		send_item(MODE_DEC, 8'h00, 1'b0);
		send_item(MODE_DEC, 8'hff, 1'b1);
		// unused codes, segment mark on silent modes
		send_item(MODE_SPARE_LO, 8'hff, 1'b1);
		send_item(MODE_SPARE_HI, 8'h00, 1'b1);
		send_item(MODE_STREAM, 8'hff, 1'b1);
		send_item(MODE_INIT, 8'hff, 1'b1);
		send_item(MODE_KEY, 8'h00, 1'b1);
		send_item(MODE_KEY, 8'hff, 1'b0);
		send_item(MODE_KEY, 8'ha5, 1'b0);
		send_item(MODE_KEY, 8'h5a, 1'b1);
		send_item(MODE_WARMUP, 8'hff, 1'b1);
		send_item(MODE_STREAM, 8'h00, 1'b1);
		send_item(MODE_ENC, 8'h5a, 1'b0);
		send_item(MODE_DEC, 8'ha5, 1'b1);
		// key byte with nonzero index i, then warmup clears both indices again
		send_item(MODE_KEY, 8'h3c, 1'b0);
		send_item(MODE_WARMUP, 8'h00, 1'b0);
		send_item(MODE_ENC, 8'hff, 1'b0);
		send_item(MODE_INIT, 8'h00, 1'b0);
		send_item(MODE_DEC, 8'h80, 1'b1);
		items_sent = 0;

		run_random();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered init %0d, key %0d, warmup %0d, keystream %0d, enc %0d, dec %0d, unused %0d",
			sb.mode_seen[MODE_INIT], sb.mode_seen[MODE_KEY], sb.mode_seen[MODE_WARMUP],
			sb.mode_seen[MODE_STREAM], sb.mode_seen[MODE_ENC], sb.mode_seen[MODE_DEC],
			sb.mode_seen[MODE_SPARE_LO] + sb.mode_seen[MODE_SPARE_HI]);
		$display("%0d result bytes compared, %0d failures, %0d left over",
			sb.checked_count, sb.fail_count, sb.pending());
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/arc4dk_pkg.sv
hw/rtl/arc4dk_if.sv
hw/rtl/arc4dk_ram.sv
hw/rtl/arc4dk_datapath.sv
hw/rtl/arc4dk_ctrl.sv
hw/rtl/arc4_double_keystream_cipher_core.sv
hw/rtl/arc4dk_checker.sv
verif/arc4_double_keystream_cipher_core_tb.sv
